// ----- rtl/core/ltbfs_pkg.sv -----
package ltbfs_pkg;

  localparam int unsigned FramePixels = 1024;
  localparam int unsigned PixAw = $clog2(FramePixels);
  localparam int unsigned PosW = 13;
  localparam int unsigned UsedChannels = 4;

  localparam logic [2:0] FUNC_WRITE   = 3'd0;
  localparam logic [2:0] FUNC_READ    = 3'd1;
  localparam logic [2:0] FUNC_PUBLISH = 3'd2;
  localparam logic [2:0] FUNC_CONSUME = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STATE = 2'd1;
  localparam logic [1:0] ST_BAD_ARG   = 2'd2;
  localparam logic [1:0] ST_REFUSED   = 2'd3;

  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_LED_COUNT_0   = 3'd1;
  localparam logic [2:0] REG_LED_COUNT_1   = 3'd2;
  localparam logic [2:0] REG_LED_COUNT_2   = 3'd3;
  localparam logic [2:0] REG_LED_COUNT_3   = 3'd4;

  localparam logic [1:0] BANK_0 = 2'd0;
  localparam logic [1:0] BANK_1 = 2'd1;
  localparam logic [1:0] BANK_2 = 2'd2;

  typedef struct packed {
    logic             accept;
    logic             clr_en;
    logic [PixAw-1:0] clr_addr;
    logic             load_read;
    logic             load_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic go_read;
    logic go_clear;
  } dp_stat_t;

endpackage

// ----- rtl/core/ltbfs_ctrl.sv -----
module ltbfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ltbfs_pkg::dp_stat_t   stat_i,
  output ltbfs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_e;

  state_e                        state_q;
  logic [ltbfs_pkg::PixAw-1:0]   cnt_q;
  logic                          clr_item_q;
  logic                          last_row;
  logic                          accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign last_row   = (cnt_q == ltbfs_pkg::PixAw'(ltbfs_pkg::FramePixels - 1));

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.clr_en     = (state_q == S_CLEAR);
    cmd_o.clr_addr   = cnt_q;
    cmd_o.load_read  = (state_q == S_READ);
    cmd_o.load_clear = (state_q == S_CLEAR) && last_row && clr_item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      clr_item_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_row) begin
            state_q    <= S_IDLE;
            clr_item_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept && stat_i.go_read) begin
            state_q <= S_READ;
          end else if (accept && stat_i.go_clear) begin
            state_q    <= S_CLEAR;
            cnt_q      <= '0;
            clr_item_q <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ltbfs_datapath.sv -----
module ltbfs_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ltbfs_pkg::ctrl_cmd_t  cmd_i,
  output ltbfs_pkg::dp_stat_t   stat_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  input  logic [2:0]            func_i,
  input  logic [1:0]            channel_i,
  input  logic [9:0]            index_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [10:0]           channel_leds_o
);

  localparam int unsigned Aw = ltbfs_pkg::PixAw;
  localparam int unsigned Pw = ltbfs_pkg::PosW;
  localparam int unsigned Depth = ltbfs_pkg::FramePixels;

  logic [2:0]  chan_count_q;
  logic [10:0] led_count_q [ltbfs_pkg::UsedChannels];
  logic [2:0]  reg_idx;
  logic        cfg_we;

  logic [1:0]  front_q;
  logic [1:0]  back_q;
  logic [1:0]  third_q;
  logic        pending_q;

  logic [Pw-1:0] off [ltbfs_pkg::UsedChannels + 1];
  logic [Pw-1:0] total;
  logic [Pw-1:0] pos;
  logic          counts_ok;
  logic          cfg_valid;
  logic          arg_ok;
  logic [1:0]    imm_status;
  logic          wr_ok;
  logic          rd_en;

  logic [23:0]   mem0 [Depth];
  logic [23:0]   mem1 [Depth];
  logic [23:0]   mem2 [Depth];
  logic [Aw-1:0] waddr;
  logic [23:0]   wdata;
  logic          we0;
  logic          we1;
  logic          we2;
  logic [23:0]   rd0_q;
  logic [23:0]   rd1_q;
  logic [23:0]   rd2_q;
  logic [1:0]    rd_sel_q;
  logic [10:0]   rd_leds_q;
  logic [23:0]   rd_pix;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [23:0]   pix_q;
  logic [10:0]   leds_q;
  logic          imm_load;

  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q   <= 3'd1;
      led_count_q[0] <= 11'd64;
      led_count_q[1] <= 11'd0;
      led_count_q[2] <= 11'd0;
      led_count_q[3] <= 11'd0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        ltbfs_pkg::REG_CHANNEL_COUNT: chan_count_q   <= pwdata[2:0];
        ltbfs_pkg::REG_LED_COUNT_0:   led_count_q[0] <= pwdata[10:0];
        ltbfs_pkg::REG_LED_COUNT_1:   led_count_q[1] <= pwdata[10:0];
        ltbfs_pkg::REG_LED_COUNT_2:   led_count_q[2] <= pwdata[10:0];
        ltbfs_pkg::REG_LED_COUNT_3:   led_count_q[3] <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ltbfs_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, chan_count_q};
      ltbfs_pkg::REG_LED_COUNT_0:   prdata = {21'd0, led_count_q[0]};
      ltbfs_pkg::REG_LED_COUNT_1:   prdata = {21'd0, led_count_q[1]};
      ltbfs_pkg::REG_LED_COUNT_2:   prdata = {21'd0, led_count_q[2]};
      ltbfs_pkg::REG_LED_COUNT_3:   prdata = {21'd0, led_count_q[3]};
      default:                      prdata = 32'd0;
    endcase
  end

  always_comb begin
    off[0]    = '0;
    counts_ok = 1'b1;
    for (int i = 0; i < ltbfs_pkg::UsedChannels; i++) begin
      off[i+1] = off[i] + Pw'(led_count_q[i]);
      if ((3'(i) < chan_count_q) &&
          ((led_count_q[i] == 11'd0) || (led_count_q[i] > 11'd1024))) begin
        counts_ok = 1'b0;
      end
    end
    unique case (chan_count_q)
      3'd1:    total = off[1];
      3'd2:    total = off[2];
      3'd3:    total = off[3];
      3'd4:    total = off[4];
      default: total = '0;
    endcase
  end

  assign cfg_valid = (chan_count_q != 3'd0)
                  && (chan_count_q <= 3'(ltbfs_pkg::UsedChannels))
                  && counts_ok
                  && (total <= Pw'(Depth));

  assign pos    = off[{1'b0, channel_i}] + Pw'(index_i);
  assign arg_ok = ({1'b0, channel_i} < chan_count_q)
               && ({1'b0, index_i} < led_count_q[channel_i])
               && (pos < Pw'(Depth));

  always_comb begin
    if (!cfg_valid) begin
      imm_status = ltbfs_pkg::ST_BAD_STATE;
    end else begin
      unique case (func_i) inside
        ltbfs_pkg::FUNC_WRITE, ltbfs_pkg::FUNC_READ:
          imm_status = arg_ok ? ltbfs_pkg::ST_OK : ltbfs_pkg::ST_BAD_ARG;
        ltbfs_pkg::FUNC_PUBLISH:
          imm_status = pending_q ? ltbfs_pkg::ST_REFUSED : ltbfs_pkg::ST_OK;
        ltbfs_pkg::FUNC_CONSUME:
          imm_status = pending_q ? ltbfs_pkg::ST_OK : ltbfs_pkg::ST_REFUSED;
        ltbfs_pkg::FUNC_CLEAR:
          imm_status = ltbfs_pkg::ST_OK;
        default:
          imm_status = ltbfs_pkg::ST_BAD_ARG;
      endcase
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.go_read  = cfg_valid && (func_i == ltbfs_pkg::FUNC_READ) && arg_ok;
  assign stat_o.go_clear = cfg_valid && (func_i == ltbfs_pkg::FUNC_CLEAR);

  assign wr_ok = cmd_i.accept && cfg_valid && (func_i == ltbfs_pkg::FUNC_WRITE) && arg_ok;
  assign rd_en = cmd_i.accept && stat_o.go_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= ltbfs_pkg::BANK_0;
      back_q    <= ltbfs_pkg::BANK_1;
      third_q   <= ltbfs_pkg::BANK_2;
      pending_q <= 1'b0;
    end else if (cmd_i.accept && cfg_valid) begin
      if ((func_i == ltbfs_pkg::FUNC_PUBLISH) && !pending_q) begin
        back_q    <= third_q;
        third_q   <= back_q;
        pending_q <= 1'b1;
      end else if ((func_i == ltbfs_pkg::FUNC_CONSUME) && pending_q) begin
        front_q   <= third_q;
        third_q   <= front_q;
        pending_q <= 1'b0;
      end
    end
  end

  assign waddr = cmd_i.clr_en ? cmd_i.clr_addr : pos[Aw-1:0];
  assign wdata = cmd_i.clr_en ? 24'd0 : {red_i, green_i, blue_i};
  assign we0   = cmd_i.clr_en || (wr_ok && (back_q == ltbfs_pkg::BANK_0));
  assign we1   = cmd_i.clr_en || (wr_ok && (back_q == ltbfs_pkg::BANK_1));
  assign we2   = cmd_i.clr_en || (wr_ok && (back_q == ltbfs_pkg::BANK_2));

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    if (we2) begin
      mem2[waddr] <= wdata;
    end
    if (rd_en) begin
      rd0_q     <= mem0[pos[Aw-1:0]];
      rd1_q     <= mem1[pos[Aw-1:0]];
      rd2_q     <= mem2[pos[Aw-1:0]];
      rd_sel_q  <= front_q;
      rd_leds_q <= led_count_q[channel_i];
    end
  end

  always_comb begin
    case (rd_sel_q)
      ltbfs_pkg::BANK_0: rd_pix = rd0_q;
      ltbfs_pkg::BANK_1: rd_pix = rd1_q;
      default:           rd_pix = rd2_q;
    endcase
  end

  assign imm_load = cmd_i.accept && !stat_o.go_read && !stat_o.go_clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (imm_load || cmd_i.load_read || cmd_i.load_clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_load) begin
      status_q <= imm_status;
      pix_q    <= 24'd0;
      leds_q   <= 11'd0;
    end else if (cmd_i.load_read) begin
      status_q <= ltbfs_pkg::ST_OK;
      pix_q    <= rd_pix;
      leds_q   <= rd_leds_q;
    end else if (cmd_i.load_clear) begin
      status_q <= ltbfs_pkg::ST_OK;
      pix_q    <= 24'd0;
      leds_q   <= 11'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign red_out_o      = pix_q[23:16];
  assign green_out_o    = pix_q[15:8];
  assign blue_out_o     = pix_q[7:0];
  assign channel_leds_o = leds_q;

endmodule

// ----- rtl/core/led_triple_buffer_frame_store.sv -----
// Writes, publishes, consumes and refused or invalid items give their result in the cycle
// after acceptance, and a new item may be accepted in the next cycle if out_ready_i is high.
// A front pixel read gives its result after the registered read port of the bank memories
// and then the output register; the next item is taken after it.
// Clear-all sweeps one row of all three banks per cycle over all 1024 rows, then gives its result.
// After reset the same clearing pass runs with in_ready_o low.
module led_triple_buffer_frame_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [1:0]  channel_i,
  input  logic [9:0]  index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [10:0] channel_leds_o
);

  ltbfs_pkg::ctrl_cmd_t cmd;
  ltbfs_pkg::dp_stat_t  stat;

  assign pready = 1'b1;

  ltbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ltbfs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .func_i         (func_i),
    .channel_i      (channel_i),
    .index_i        (index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .channel_leds_o (channel_leds_o)
  );

endmodule

// ----- bench/tb_led_triple_buffer_frame_store.sv -----
`timescale 1ns / 100ps

module tb_led_triple_buffer_frame_store;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] chan;
    logic [9:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] leds;
  } led_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [1:0]  channel_i = '0;
  logic [9:0]  index_i = '0;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic [10:0] channel_leds_o;

  led_triple_buffer_frame_store DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .channel_i     (channel_i),
    .index_i       (index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .channel_leds_o(channel_leds_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the frame store and its layout registers.
  logic [23:0] bank_pix [3][ltbfs_pkg::FramePixels];
  logic [1:0]  front_id = ltbfs_pkg::BANK_0;
  logic [1:0]  back_id = ltbfs_pkg::BANK_1;
  logic [1:0]  spare_id = ltbfs_pkg::BANK_2;
  logic        pend_full = 1'b0;
  logic [2:0]  lay_count = 3'd1;
  logic [10:0] lay_leds [4] = '{11'd64, 11'd0, 11'd0, 11'd0};

  led_op_t     op_backlog [$];
  led_reply_t  reply_expect [$];
  led_op_t     op_cur;
  int unsigned in_hold = 0;
  int unsigned out_stall = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int unsigned fault_count = 0;

  function automatic void wipe_banks();
    bank_pix = '{default: 24'd0};
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic bit layout_ok();
    int unsigned total;
    total = 0;
    if (lay_count == 3'd0 || lay_count > 3'(ltbfs_pkg::UsedChannels)) return 1'b0;
    for (int unsigned i = 0; i < 4; i++) begin
      if (3'(i) < lay_count) begin
        if (lay_leds[i[1:0]] == 11'd0 || lay_leds[i[1:0]] > 11'd1024) return 1'b0;
        total += 32'(lay_leds[i[1:0]]);
      end
    end
    return total <= ltbfs_pkg::FramePixels;
  endfunction

  function automatic int unsigned span_base(logic [1:0] ch);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < 4; i++) begin
      if (2'(i) < ch) acc += 32'(lay_leds[i[1:0]]);
    end
    return acc;
  endfunction

  function automatic led_reply_t store_step(led_op_t op);
    led_reply_t  rsp;
    int unsigned pos;
    logic [1:0]  swap;
    rsp = '0;
    if (!layout_ok()) begin
      rsp.status = ltbfs_pkg::ST_BAD_STATE;
    end else begin
      case (op.func) inside
        ltbfs_pkg::FUNC_WRITE, ltbfs_pkg::FUNC_READ: begin
          pos = span_base(op.chan) + 32'(op.idx);
          if ({1'b0, op.chan} >= lay_count || {1'b0, op.idx} >= lay_leds[op.chan] ||
              pos >= ltbfs_pkg::FramePixels) begin
            rsp.status = ltbfs_pkg::ST_BAD_ARG;
          end else if (op.func == ltbfs_pkg::FUNC_WRITE) begin
            bank_pix[back_id][pos[ltbfs_pkg::PixAw-1:0]] = {op.red, op.green, op.blue};
          end else begin
            {rsp.red, rsp.green, rsp.blue} = bank_pix[front_id][pos[ltbfs_pkg::PixAw-1:0]];
            rsp.leds = lay_leds[op.chan];
          end
        end
        ltbfs_pkg::FUNC_PUBLISH: begin
          if (pend_full) begin
            rsp.status = ltbfs_pkg::ST_REFUSED;
          end else begin
            swap = back_id;
            back_id = spare_id;
            spare_id = swap;
            pend_full = 1'b1;
          end
        end
        ltbfs_pkg::FUNC_CONSUME: begin
          if (!pend_full) begin
            rsp.status = ltbfs_pkg::ST_REFUSED;
          end else begin
            swap = front_id;
            front_id = spare_id;
            spare_id = swap;
            pend_full = 1'b0;
          end
        end
        ltbfs_pkg::FUNC_CLEAR: begin
          wipe_banks();
        end
        default: begin
          rsp.status = ltbfs_pkg::ST_BAD_ARG;
        end
      endcase
    end
    return rsp;
  endfunction

  function automatic int unsigned pick_idle(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin : op_driver
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) reply_expect.push_back(store_step(op_cur));
      if (!in_valid_i || in_ready_o) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid_i <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          op_cur = op_backlog.pop_front();
          func_i <= op_cur.func;
          channel_i <= op_cur.chan;
          index_i <= op_cur.idx;
          red_i <= op_cur.red;
          green_i <= op_cur.green;
          blue_i <= op_cur.blue;
          in_valid_i <= 1'b1;
          in_hold = pick_idle(calm_in);
          if ($urandom_range(0, 149) == 0) calm_in = !calm_in;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic note_fault(string what, led_reply_t want, led_reply_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s: expected status=%0d rgb=%06h leds=%0d", $realtime, what,
               want.status, {want.red, want.green, want.blue}, want.leds);
      $display("%0t: %s: actual   status=%0d rgb=%06h leds=%0d", $realtime, what,
               got.status, {got.red, got.green, got.blue}, got.leds);
    end
  endtask

  always @(posedge clk_i) begin : reply_monitor
    led_reply_t got;
    led_reply_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, red_out_o, green_out_o, blue_out_o, channel_leds_o};
        if (reply_expect.size() == 0) begin
          note_fault("result with none expected", '0, got);
        end else begin
          want = reply_expect.pop_front();
          if (got !== want) begin
            note_fault("result mismatch", want, got);
          end
        end
        out_stall = pick_idle(calm_out);
        if ($urandom_range(0, 119) == 0) calm_out = !calm_out;
      end else if (!out_valid_o && out_stall == 0 && $urandom_range(0, 19) == 0) begin
        out_stall = pick_idle(calm_out);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_op(logic [2:0] f, logic [1:0] ch, logic [9:0] ix,
                         logic [7:0] r, logic [7:0] g, logic [7:0] b);
    op_backlog.push_back('{f, ch, ix, r, g, b});
  endtask

  task automatic push_ctl(logic [2:0] f);
    push_op(f, 2'($urandom), 10'($urandom), rnd8(), rnd8(), rnd8());
  endtask

  task automatic push_raw();
    push_ctl(3'($urandom_range(0, 7)));
  endtask

  task automatic pick_pixel(output logic [1:0] ch, output logic [9:0] ix);
    ch = 2'($urandom_range(0, 32'(lay_count) - 1));
    ix = 10'($urandom_range(0, 32'(lay_leds[ch]) - 1));
  endtask

  // A frame: pixel writes, usually publish and consume, then reads of those pixels.
  task automatic push_frame(inout int unsigned made);
    logic [1:0] chs [12];
    logic [9:0] ixs [12];
    int unsigned k;
    k = $urandom_range(1, 12);
    for (int unsigned i = 0; i < k; i++) begin
      pick_pixel(chs[i], ixs[i]);
      push_op(ltbfs_pkg::FUNC_WRITE, chs[i], ixs[i], rnd8(), rnd8(), rnd8());
      if ($urandom_range(0, 5) == 0) begin
        push_op(ltbfs_pkg::FUNC_READ, chs[i], ixs[i], rnd8(), rnd8(), rnd8());
      end
    end
    if ($urandom_range(0, 9) != 0) push_ctl(ltbfs_pkg::FUNC_PUBLISH);
    if ($urandom_range(0, 9) < 8) push_ctl(ltbfs_pkg::FUNC_CONSUME);
    for (int unsigned i = 0; i < k; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        push_op(ltbfs_pkg::FUNC_READ, chs[i], ixs[i], rnd8(), rnd8(), rnd8());
      end
    end
    if ($urandom_range(0, 39) == 0) push_ctl(ltbfs_pkg::FUNC_CLEAR);
    made += 2 * k + 2;
  endtask

  task automatic push_single();
    int unsigned r;
    logic [1:0] ch;
    logic [9:0] ix;
    r = $urandom_range(0, 99);
    pick_pixel(ch, ix);
    if (r < 40) begin
      push_op(ltbfs_pkg::FUNC_WRITE, ch, ix, rnd8(), rnd8(), rnd8());
    end else if (r < 70) begin
      push_op(ltbfs_pkg::FUNC_READ, ch, ix, rnd8(), rnd8(), rnd8());
    end else if (r < 76) begin
      push_ctl(ltbfs_pkg::FUNC_PUBLISH);
    end else if (r < 82) begin
      push_ctl(ltbfs_pkg::FUNC_CONSUME);
    end else if (r < 83) begin
      push_ctl(ltbfs_pkg::FUNC_CLEAR);
    end else if (r < 88) begin
      push_ctl(3'($urandom_range(32'(ltbfs_pkg::FUNC_CLEAR) + 1, 7)));
    end else if (r < 94) begin
      ch = 2'($urandom);
      if ({1'b0, ch} < lay_count && lay_leds[ch] < 11'd1024) begin
        ix = 10'($urandom_range(32'(lay_leds[ch]), 1023));
      end else begin
        ix = 10'($urandom);
      end
      push_op(3'($urandom_range(0, 1)), ch, ix, rnd8(), rnd8(), rnd8());
    end else begin
      push_raw();
    end
  endtask

  task automatic run_valid_phase(int unsigned n);
    int unsigned made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 1) == 0) begin
        push_frame(made);
      end else begin
        push_single();
        made++;
      end
    end
  endtask

  task automatic run_bad_phase(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_raw();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (op_backlog.size() != 0 || in_valid_i || reply_expect.size() != 0);
  endtask

  task automatic reg_write(logic [2:0] reg_id, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_id)
      ltbfs_pkg::REG_CHANNEL_COUNT: lay_count = value[2:0];
      ltbfs_pkg::REG_LED_COUNT_0: lay_leds[0] = value[10:0];
      ltbfs_pkg::REG_LED_COUNT_1: lay_leds[1] = value[10:0];
      ltbfs_pkg::REG_LED_COUNT_2: lay_leds[2] = value[10:0];
      ltbfs_pkg::REG_LED_COUNT_3: lay_leds[3] = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(logic [2:0] n, logic [10:0] l0, logic [10:0] l1,
                            logic [10:0] l2, logic [10:0] l3);
    wait_idle();
    repeat (4) @(posedge clk_i);
    reg_write(ltbfs_pkg::REG_CHANNEL_COUNT, {29'd0, n});
    reg_write(ltbfs_pkg::REG_LED_COUNT_0, {21'd0, l0});
    reg_write(ltbfs_pkg::REG_LED_COUNT_1, {21'd0, l1});
    reg_write(ltbfs_pkg::REG_LED_COUNT_2, {21'd0, l2});
    reg_write(ltbfs_pkg::REG_LED_COUNT_3, {21'd0, l3});
    @(negedge clk_i);
  endtask

  task automatic set_random_layout();
    logic [10:0] v [4];
    int unsigned n;
    int unsigned left;
    int unsigned hi;
    n = $urandom_range(1, 4);
    left = ltbfs_pkg::FramePixels;
    for (int unsigned i = 0; i < 4; i++) begin
      if (i < n) begin
        hi = left - (n - 1 - i);
        if ($urandom_range(0, 2) != 0 && hi > 64) hi = 64;
        v[i[1:0]] = 11'($urandom_range(1, hi));
        left -= 32'(v[i[1:0]]);
      end else begin
        v[i[1:0]] = 11'($urandom_range(0, 2047));
      end
    end
    set_layout(3'(n), v[0], v[1], v[2], v[3]);
  endtask

  initial begin : stimulus
    int f;
    int i;
    wipe_banks();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items on the reset layout of one channel with 64 LEDs.
    push_op(ltbfs_pkg::FUNC_READ, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_WRITE, 2'd0, 10'd0, 8'hff, 8'hff, 8'hff);
    push_op(ltbfs_pkg::FUNC_WRITE, 2'd0, 10'd63, 8'h01, 8'h80, 8'h7f);
    push_op(ltbfs_pkg::FUNC_WRITE, 2'd0, 10'd64, 8'h12, 8'h34, 8'h56);
    push_op(ltbfs_pkg::FUNC_WRITE, 2'd1, 10'd0, 8'h12, 8'h34, 8'h56);
    push_op(ltbfs_pkg::FUNC_READ, 2'd3, 10'd1023, 8'hff, 8'hff, 8'hff);
    push_op(ltbfs_pkg::FUNC_CONSUME, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_PUBLISH, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_PUBLISH, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_READ, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_CONSUME, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_READ, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_READ, 2'd0, 10'd63, 8'h00, 8'h00, 8'h00);
    for (f = 32'(ltbfs_pkg::FUNC_CLEAR) + 1; f <= 7; f++) begin
      push_op(3'(f), 2'd3, 10'd1023, 8'hff, 8'hff, 8'hff);
    end
    push_op(ltbfs_pkg::FUNC_CLEAR, 2'd3, 10'd1023, 8'hff, 8'hff, 8'hff);
    push_op(ltbfs_pkg::FUNC_READ, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_WRITE, 2'd0, 10'd5, 8'h00, 8'h00, 8'h00);
    push_op(ltbfs_pkg::FUNC_CONSUME, 2'd0, 10'd0, 8'h00, 8'h00, 8'h00);

    set_layout(3'd4, 11'd1, 11'd1, 11'd1, 11'd1);
    run_valid_phase(150);
    set_layout(3'd1, 11'd1024, 11'd2047, 11'd0, 11'd1024);
    run_valid_phase(200);
    set_layout(3'd0, 11'd64, 11'd64, 11'd64, 11'd64);
    run_bad_phase(15);
    set_layout(3'd4, 11'd256, 11'd256, 11'd256, 11'd256);
    run_valid_phase(200);
    set_layout(3'd5, 11'd1, 11'd1, 11'd1, 11'd1);
    run_bad_phase(10);
    set_layout(3'd7, 11'd1, 11'd1, 11'd1, 11'd1);
    run_bad_phase(10);
    set_layout(3'd2, 11'd600, 11'd600, 11'd0, 11'd0);
    run_bad_phase(10);
    set_layout(3'd2, 11'd0, 11'd5, 11'd0, 11'd0);
    run_bad_phase(10);
    set_layout(3'd1, 11'd2047, 11'd0, 11'd0, 11'd0);
    run_bad_phase(10);
    set_layout(3'd3, 11'd500, 11'd300, 11'd224, 11'd2047);
    run_valid_phase(200);
    set_layout(3'd2, 11'd1000, 11'd24, 11'd7, 11'd0);
    run_valid_phase(200);
    for (i = 0; i < 4; i++) begin
      set_random_layout();
      run_valid_phase(150);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && reply_expect.size() == 0) begin
      $display("** led_triple_buffer_frame_store: PASSED **");
    end else begin
      $display("** led_triple_buffer_frame_store: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("** led_triple_buffer_frame_store: FAILED **");
    $finish;
  end

endmodule
